// ----- sv/bit_range_blitter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bit range blitter
// Shorthand for clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef BIT_RANGE_BLITTER_MACROS_SVH
`define BIT_RANGE_BLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit range blitter package
// Function and raster op codes, stream widths and the command record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brb_pkg;

    localparam int          WORD_BITS = 32;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [4:0]  LAST_BIT  = 5'd31;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    localparam logic [1:0] FUNC_LOAD_SRC = 2'd0;
    localparam logic [1:0] FUNC_LOAD_DST = 2'd1;
    localparam logic [1:0] FUNC_BLIT     = 2'd2;
    localparam logic [1:0] FUNC_READ     = 2'd3;

    localparam logic [2:0] OP_COPY   = 3'd0;
    localparam logic [2:0] OP_INVERT = 3'd1;
    localparam logic [2:0] OP_AND    = 3'd2;
    localparam logic [2:0] OP_OR     = 3'd3;
    localparam logic [2:0] OP_XOR    = 3'd4;

    // Classified command handed from the front end to the execution side.
    typedef struct packed {
        logic [1:0]  func;
        logic        act;      // store index in range, or blit with bits to move
        logic        clamped;  // blit width cut at the destination end
        logic [2:0]  op;
        logic [4:0]  sh;       // source funnel shift
        logic [4:0]  head;     // first bit in the first destination word
        logic [4:0]  tail;     // last bit in the last destination word
        logic [31:0] data;
    } brb_cmd_t;

endpackage

// ----- sv/bit_range_blitter.sv -----
// ----------------------------------------------------------------------------
// Bit range blitter
// One-dimensional raster-op blitter over a source and a destination store.
// ----------------------------------------------------------------------------
// The block holds two stores of WORDS 32-bit words; bit k of a store is bit
// k mod 32 of word k / 32. Each input transfer loads a source word, loads a
// destination word, reads a destination word, or runs a blit that combines
// bit_count source bits from src_bit onward into the destination bits from
// dst_bit onward with copy, invert, and, or or xor. Every input transfer
// gives exactly one output transfer, in order. A front end classifies each
// transfer (clamp at the destination end, first and last destination word,
// funnel shift) and hands it through a two-entry queue to the execution
// side, so up to two further transfers are taken while a blit runs or a
// result waits. The execution side takes a transfer off the queue at the
// earliest in the cycle after its input transfer. A load, or a blit that
// moves no bits, writes the result register as it is taken; a read passes
// through a read state first. A blit covering N destination words, up to
// WORDS, runs one run state per word and then a drain state: the execution
// side does one destination read-modify-write per cycle, pipelined over one
// read and one write port of the destination RAM, while the source RAM
// streams one word per cycle into a 64-bit funnel. Source bits beyond the
// store read as zero; a blit that runs past the destination end is cut
// there and reports status 1. Unknown raster ops leave the destination as
// it is. Both stores come up undefined and need no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_range_blitter #(
    parameter int WORDS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] func
    input  logic [brb_pkg::S_TUSER_W-1:0] s_tuser,
    // [7:0] index, [39:8] data, [52:40] dst_bit, [65:53] src_bit,
    // [79:66] bit_count, [82:80] op, [87:83] zero
    input  logic [brb_pkg::S_TDATA_W-1:0] s_tdata,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] read_word, [32] status, [39:33] zero
    output logic [brb_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(WORDS);
    localparam int KW = $clog2(WORDS + 257) + 1;
    localparam int QW = $bits(brb_pkg::brb_cmd_t) + 2 * AW + KW;

    // Front end to queue.
    brb_pkg::brb_cmd_t f_cmd;
    logic [AW-1:0]     f_wi0;
    logic [AW-1:0]     f_wlast;
    logic [KW-1:0]     f_k0;
    logic              push;
    logic              full;

    // Queue to execution side.
    brb_pkg::brb_cmd_t b_cmd;
    logic [AW-1:0]     b_wi0;
    logic [AW-1:0]     b_wlast;
    logic [KW-1:0]     b_k0;
    logic              pop;
    logic              empty;
    logic [QW-1:0]     q_in;
    logic [QW-1:0]     q_head;

    brb_front #(
        .WORDS (WORDS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .full     (full),
        .push     (push),
        .cmd      (f_cmd),
        .wi0      (f_wi0),
        .wlast    (f_wlast),
        .k0       (f_k0)
    );

    // Pack the classified transfer for the queue, unpack at its head.
    assign q_in = {f_cmd, f_wi0, f_wlast, f_k0};
    assign {b_cmd, b_wi0, b_wlast, b_k0} = q_head;

    brb_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (q_head)
    );

    brb_back #(
        .WORDS (WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_cmd    (b_cmd),
        .q_wi0    (b_wi0),
        .q_wlast  (b_wlast),
        .q_k0     (b_k0),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/brb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/brb_front.sv -----
// ----------------------------------------------------------------------------
// Bit range blitter front end
// Unpack input transfers, clamp blits and work out word ranges and shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_front #(
    parameter int WORDS = 256,
    localparam int AW = $clog2(WORDS),
    localparam int KW = $clog2(WORDS + 257) + 1
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [brb_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic [brb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            full,
    output logic                            push,
    output brb_pkg::brb_cmd_t               cmd,
    output logic [AW-1:0]                   wi0,
    output logic [AW-1:0]                   wlast,
    output logic [KW-1:0]                   k0
);

    localparam int POS_W = (AW + 6 > 15) ? AW + 6 : 15;
    localparam logic [POS_W-1:0] TOTAL = POS_W'(WORDS * brb_pkg::WORD_BITS);

    logic [1:0]  func;
    logic [7:0]  index;
    logic [31:0] data;
    logic [12:0] dst_bit;
    logic [12:0] src_bit;
    logic [13:0] bit_count;
    logic [2:0]  op;

    logic [POS_W-1:0] dst_p;
    logic [POS_W-1:0] end_p;
    logic [POS_W-1:0] last_p;
    logic             clamped;
    logic             has_work;
    logic             idx_ok;
    logic             is_blit;
    logic signed [13:0] src_adj;

    assign func      = s_tuser[1:0];
    assign index     = s_tdata[7:0];
    assign data      = s_tdata[39:8];
    assign dst_bit   = s_tdata[52:40];
    assign src_bit   = s_tdata[65:53];
    assign bit_count = s_tdata[79:66];
    assign op        = s_tdata[82:80];

    assign is_blit = (func == brb_pkg::FUNC_BLIT);

    // Clamp the run at the destination end; last_p is the final bit touched.
    assign dst_p    = POS_W'(dst_bit);
    assign end_p    = dst_p + POS_W'(bit_count);
    assign clamped  = (end_p > TOTAL);
    assign last_p   = clamped ? (TOTAL - POS_W'(1)) : (end_p - POS_W'(1));
    assign has_work = (bit_count != 14'd0) && (dst_p < TOTAL) && (op <= brb_pkg::OP_XOR);
    assign idx_ok   = (32'(index) < 32'(WORDS));

    // Source word aligned with the first destination word, and the funnel shift.
    assign src_adj = $signed({1'b0, src_bit}) - $signed({9'b0, dst_bit[4:0]});

    always_comb
    begin
        cmd.func    = func;
        cmd.act     = is_blit ? has_work : idx_ok;
        cmd.clamped = is_blit && clamped;
        cmd.op      = op;
        cmd.sh      = src_adj[4:0];
        cmd.head    = dst_bit[4:0];
        cmd.tail    = last_p[4:0];
        cmd.data    = data;
    end

    assign wi0      = is_blit ? dst_p[AW+4:5] : (idx_ok ? AW'(index) : '0);
    assign wlast    = last_p[AW+4:5];
    assign k0       = KW'(src_adj >>> 5);
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

endmodule

// ----- sv/brb_queue.sv -----
// ----------------------------------------------------------------------------
// Bit range blitter command queue
// Two-entry FIFO between the front end and the execution side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_queue #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output logic [W-1:0] head
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_next;
    logic [1:0]   count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/brb_back.sv -----
// ----------------------------------------------------------------------------
// Bit range blitter execution side
// Own both word stores, run loads, reads and blits, hold the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brb_back #(
    parameter int WORDS = 256,
    localparam int AW = $clog2(WORDS),
    localparam int KW = $clog2(WORDS + 257) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  brb_pkg::brb_cmd_t             q_cmd,
    input  logic [AW-1:0]                 q_wi0,
    input  logic [AW-1:0]                 q_wlast,
    input  logic [KW-1:0]                 q_k0,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RUN, ST_DRAIN} state_t;

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [4:0]  sh_reg, sh_next;
    logic [4:0]  head_reg, head_next;
    logic [4:0]  tail_reg, tail_next;
    logic        clamped_reg, clamped_next;
    logic        act_reg, act_next;
    logic [AW-1:0] wi_reg, wi_next;
    logic [AW-1:0] wlast_reg, wlast_next;
    logic [KW-1:0] k_reg, k_next;
    logic        first_reg, first_next;
    logic        s1_vld_reg, s1_vld_next;
    logic [AW-1:0] s1_wi_reg, s1_wi_next;
    logic        s1_first_reg, s1_first_next;
    logic        s1_last_reg, s1_last_next;
    logic        src_rvld_reg, src_rvld_next;
    logic        out_vld_reg, out_vld_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        out_status_reg, out_status_next;
    logic [31:0] hold_reg;

    logic        start;
    logic        prod;
    logic [31:0] prod_word;
    logic        prod_status;

    logic          src_we;
    logic [AW-1:0] src_raddr;
    logic [31:0]   src_rdata;
    logic [31:0]   src_cur;
    logic [KW-1:0] k_sel;
    logic          src_ok;
    logic          src_rd_en;

    logic          dst_we;
    logic [AW-1:0] dst_waddr;
    logic [31:0]   dst_wdata;
    logic [AW-1:0] dst_raddr;
    logic [31:0]   dst_rdata;

    logic [63:0] funnel;
    logic [4:0]  mask_lo;
    logic [4:0]  mask_hi;
    logic [31:0] mask;
    logic [31:0] merged;

    function automatic logic [31:0] raster(input logic [31:0] d, input logic [31:0] s,
                                           input logic [31:0] m, input logic [2:0] op);
        logic [31:0] r;
        logic        keep;
        r    = s;
        keep = 1'b0;
        case (op)
            brb_pkg::OP_COPY:   r = s;
            brb_pkg::OP_INVERT: r = ~s;
            brb_pkg::OP_AND:    r = s & d;
            brb_pkg::OP_OR:     r = s | d;
            brb_pkg::OP_XOR:    r = s ^ d;
            default:            keep = 1'b1;
        endcase
        return keep ? d : ((d & ~m) | (r & m));
    endfunction

    assign start = (state_reg == ST_IDLE) && !q_empty && (!out_vld_reg || m_tready);
    assign pop   = start;

    // Source side: the next word of the funnel, zero outside the store.
    assign k_sel     = (state_reg == ST_RUN) ? k_reg : q_k0;
    assign src_ok    = !k_sel[KW-1] && (k_sel[KW-2:0] < (KW-1)'(WORDS));
    assign src_raddr = src_ok ? k_sel[AW-1:0] : '0;
    assign src_rd_en = (state_reg == ST_RUN)
                    || (start && (q_cmd.func == brb_pkg::FUNC_BLIT) && q_cmd.act);
    assign src_we    = start && (q_cmd.func == brb_pkg::FUNC_LOAD_SRC) && q_cmd.act;
    assign src_cur   = src_rvld_reg ? src_rdata : '0;

    // Write stage of the destination read-modify-write.
    assign funnel  = {src_cur, hold_reg} >> sh_reg;
    assign mask_lo = s1_first_reg ? head_reg : 5'd0;
    assign mask_hi = s1_last_reg ? tail_reg : brb_pkg::LAST_BIT;
    assign mask    = (brb_pkg::ALL_ONES << mask_lo)
                   & (brb_pkg::ALL_ONES >> (brb_pkg::LAST_BIT - mask_hi));
    assign merged  = raster(dst_rdata, funnel[31:0], mask, op_reg);

    assign dst_we    = s1_vld_reg
                    || (start && (q_cmd.func == brb_pkg::FUNC_LOAD_DST) && q_cmd.act);
    assign dst_waddr = s1_vld_reg ? s1_wi_reg : q_wi0;
    assign dst_wdata = s1_vld_reg ? merged : q_cmd.data;
    assign dst_raddr = (state_reg == ST_RUN) ? wi_reg : q_wi0;

    brb_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (q_wi0),
        .wdata (q_cmd.data),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    brb_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_dst_ram (
        .clk   (clk),
        .we    (dst_we),
        .waddr (dst_waddr),
        .wdata (dst_wdata),
        .raddr (dst_raddr),
        .rdata (dst_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sh_next         = sh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        clamped_next    = clamped_reg;
        act_next        = act_reg;
        wi_next         = wi_reg;
        wlast_next      = wlast_reg;
        k_next          = k_reg;
        first_next      = first_reg;
        s1_vld_next     = 1'b0;
        s1_wi_next      = s1_wi_reg;
        s1_first_next   = s1_first_reg;
        s1_last_next    = s1_last_reg;
        src_rvld_next   = src_rd_en && src_ok;
        prod            = 1'b0;
        prod_word       = '0;
        prod_status     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (q_cmd.func) inside
                        brb_pkg::FUNC_LOAD_SRC, brb_pkg::FUNC_LOAD_DST:
                        begin
                            prod = 1'b1;
                        end
                        brb_pkg::FUNC_BLIT:
                        begin
                            clamped_next = q_cmd.clamped;
                            if (q_cmd.act)
                            begin
                                state_next = ST_RUN;
                                op_next    = q_cmd.op;
                                sh_next    = q_cmd.sh;
                                head_next  = q_cmd.head;
                                tail_next  = q_cmd.tail;
                                wi_next    = q_wi0;
                                wlast_next = q_wlast;
                                k_next     = q_k0 + KW'(1);
                                first_next = 1'b1;
                            end
                            else
                            begin
                                prod        = 1'b1;
                                prod_status = q_cmd.clamped;
                            end
                        end
                        brb_pkg::FUNC_READ:
                        begin
                            state_next = ST_READ;
                            act_next   = q_cmd.act;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                prod       = 1'b1;
                prod_word  = act_reg ? dst_rdata : '0;
                state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                s1_vld_next   = 1'b1;
                s1_wi_next    = wi_reg;
                s1_first_next = first_reg;
                s1_last_next  = (wi_reg == wlast_reg);
                first_next    = 1'b0;
                wi_next       = wi_reg + AW'(1);
                k_next        = k_reg + KW'(1);
                if (wi_reg == wlast_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                prod        = 1'b1;
                prod_status = clamped_reg;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_vld_next    = prod || (out_vld_reg && !m_tready);
        out_word_next   = prod ? prod_word : out_word_reg;
        out_status_next = prod ? prod_status : out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= brb_pkg::OP_COPY;
            sh_reg         <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            clamped_reg    <= 1'b0;
            act_reg        <= 1'b0;
            wi_reg         <= '0;
            wlast_reg      <= '0;
            k_reg          <= '0;
            first_reg      <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s1_wi_reg      <= '0;
            s1_first_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            src_rvld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_word_reg   <= '0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            sh_reg         <= sh_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            clamped_reg    <= clamped_next;
            act_reg        <= act_next;
            wi_reg         <= wi_next;
            wlast_reg      <= wlast_next;
            k_reg          <= k_next;
            first_reg      <= first_next;
            s1_vld_reg     <= s1_vld_next;
            s1_wi_reg      <= s1_wi_next;
            s1_first_reg   <= s1_first_next;
            s1_last_reg    <= s1_last_next;
            src_rvld_reg   <= src_rvld_next;
            out_vld_reg    <= out_vld_next;
            out_word_reg   <= out_word_next;
            out_status_reg <= out_status_next;
        end
    end

    // Keep the lower funnel word; it is the previous source word read.
    always_ff @(posedge clk)
    begin
        hold_reg <= src_cur;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_status_reg, out_word_reg};

endmodule

// ----- sv/bit_range_blitter_checker.sv -----
// ----------------------------------------------------------------------------
// Bit range blitter port checker
// Watch the stream ports of the blitter over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bit_range_blitter_macros.svh"

module bit_range_blitter_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [brb_pkg::M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result.
    `BRB_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `BRB_ASSERT_NXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    // Pad bits of a result stay zero.
    `BRB_ASSERT_IMP(a_out_pad, clk, rst_n, m_tvalid, m_tdata[39:33] == 7'd0, "nonzero result pad bits")
    // Leave reset with no result pending and the queue open.
    `BRB_ASSERT_IMP(a_reset_exit, clk, rst_n, $rose(rst_n), !m_tvalid && s_tready, "state after reset")

endmodule

bind bit_range_blitter bit_range_blitter_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
